>>> hdl/mlfr_pkg.sv
// ----------------------------------------------------------------------------
// mlfr_pkg
// Shared types for the MUSCL limited face reconstruction block: limiter codes
// and the width of the configuration register.
// ----------------------------------------------------------------------------
package mlfr_pkg;

	localparam int CFG_BITS = 2;

	typedef enum logic [CFG_BITS-1:0] {
		LIM_NONE       = 2'd0,
		LIM_VAN_ALBADA = 2'd1,
		LIM_VAN_LEER   = 2'd2,
		LIM_MINMOD     = 2'd3
	} limiter_kind_t;

endpackage

>>> hdl/mlfr_if.sv
// ----------------------------------------------------------------------------
// mlfr channel interfaces
// Valid/ready channels for cell samples in, face values out, and the limiter
// select register write.
// ----------------------------------------------------------------------------
interface mlfr_in_if #(parameter int WORD_BITS = 32);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] far_left;
	logic signed [WORD_BITS-1:0] near_left;
	logic signed [WORD_BITS-1:0] near_right;
	logic signed [WORD_BITS-1:0] far_right;

	modport source (output valid, far_left, near_left, near_right, far_right, input ready);
	modport sink (input valid, far_left, near_left, near_right, far_right, output ready);
endinterface

interface mlfr_out_if #(parameter int WORD_BITS = 32);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] left_face;
	logic signed [WORD_BITS-1:0] right_face;

	modport source (output valid, left_face, right_face, input ready);
	modport sink (input valid, left_face, right_face, output ready);
endinterface

interface mlfr_cfg_if;
	logic                    valid;
	logic                    ready;
	mlfr_pkg::limiter_kind_t data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> hdl/mlfr_div_pipe.sv
// ----------------------------------------------------------------------------
// mlfr_div_pipe
// Pipelined restoring divider, one quotient bit per stage. Caller supplies a
// starting remainder below the divisor, so the quotient fits QW bits.
// ----------------------------------------------------------------------------
module mlfr_div_pipe #(
	parameter int DW = 34,
	parameter int QW = 31,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rem,
	input  logic [QW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [PW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic [PW-1:0] out_side
);

	// stage registers, entry k holds the result of step k
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] num_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [PW-1:0] side_s [QW];
	logic          vld_s  [QW];

	// inputs of each step
	logic [DW-1:0] cur_rem  [QW];
	logic [QW-1:0] cur_num  [QW];
	logic [DW-1:0] cur_den  [QW];
	logic [QW-1:0] cur_quo  [QW];
	logic [PW-1:0] cur_side [QW];
	logic          cur_vld  [QW];
	logic [DW:0]   trial    [QW];
	logic [DW:0]   diff     [QW];
	logic          ge       [QW];

	always_comb begin
		cur_rem[0]  = in_rem;
		cur_num[0]  = in_num;
		cur_den[0]  = in_den;
		cur_quo[0]  = '0;
		cur_side[0] = in_side;
		cur_vld[0]  = in_valid;
		for (int k = 1; k < QW; k++) begin
			cur_rem[k]  = rem_s[k-1];
			cur_num[k]  = num_s[k-1];
			cur_den[k]  = den_s[k-1];
			cur_quo[k]  = quo_s[k-1];
			cur_side[k] = side_s[k-1];
			cur_vld[k]  = vld_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			trial[k] = {cur_rem[k], cur_num[k][QW-1]};
			diff[k]  = trial[k] - {1'b0, cur_den[k]};
			ge[k]    = trial[k] >= {1'b0, cur_den[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) vld_s[k] <= 1'b0;
		end else if (ce) begin
			for (int k = 0; k < QW; k++) vld_s[k] <= cur_vld[k];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k]  <= ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
				num_s[k]  <= cur_num[k] << 1;
				den_s[k]  <= cur_den[k];
				quo_s[k]  <= {cur_quo[k][QW-2:0], ge[k]};
				side_s[k] <= cur_side[k];
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

>>> hdl/muscl_limited_face_reconstruct.sv
// ----------------------------------------------------------------------------
// muscl_limited_face_reconstruct
// Pipe: S1, S2, the bit-per-stage ratio dividers, S3, S4, S5, the limiter
// dividers, then S6, S7 and S8, which is the output register.
// Throughput: one beat per cycle; the whole pipe advances together when the
// output register is empty or taken, and the first stage refills a bubble.
// Reset: valid bits clear, limiter select returns to none; data regs hold.
// ----------------------------------------------------------------------------
module muscl_limited_face_reconstruct #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input logic         clk,
	input logic         arst_n,
	mlfr_in_if.sink     samples,
	mlfr_out_if.source  faces,
	mlfr_cfg_if.sink    cfg
);

	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int RM  = W - 1;                          // ratio magnitude bits
	localparam int LNW = RM + W + F;                     // limiter numerator
	localparam int LDW = ((2 * RM > 2 * F) ? 2 * RM : 2 * F) + 1;  // limiter divisor
	localparam int PHW = F + 2;                          // signed phi width

	localparam logic [W:0]   ONE_X = (W + 1)'(1) << F;
	localparam logic [W-1:0] ONE_W = W'(1) << F;
	localparam logic [LDW-1:0] ONE_SQ = LDW'(1) << (2 * F);

	// side data carried through the ratio divider
	typedef struct packed {
		logic                sat;
		logic                neg;
		logic signed [W-1:0] base;   // wl for the left face, wr for the right
		logic signed [W:0]   diff;   // d1 left, d2 right
	} ratio_side_t;

	// side data carried through the limiter divider
	typedef struct packed {
		logic                  use_div;
		logic                  neg;
		logic signed [PHW-1:0] byp;
		logic signed [W-1:0]   base;
		logic signed [W:0]     diff;
	} lim_side_t;

	function automatic logic [W:0] mag_f(input logic signed [W:0] v);
		mag_f = v[W] ? (W + 1)'(-v) : (W + 1)'(v);
	endfunction

	// ------------------------------------------------------------------
	// Flow control: one enable for the whole pipe; stage 1 may also load
	// while stalled if it holds nothing.
	// ------------------------------------------------------------------
	logic ce, ld1;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_da, v_dc;
	logic v_da_r, v_dc_r;   // right-lane copies, same timing as left

	assign ce  = !v_s8 || faces.ready;
	assign ld1 = ce || !v_s1;
	assign samples.ready = ld1;

	// ------------------------------------------------------------------
	// Limiter select register
	// ------------------------------------------------------------------
	mlfr_pkg::limiter_kind_t kind_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= mlfr_pkg::LIM_NONE;
		end else if (cfg.valid) begin
			kind_q <= cfg.data;
		end
	end

	// ------------------------------------------------------------------
	// Valid chain outside the dividers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= samples.valid;
			if (ce) begin
				v_s2 <= v_s1;
				v_s3 <= v_da;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_dc;
				v_s7 <= v_s6;
				v_s8 <= v_s7;
			end
		end
	end

	// ------------------------------------------------------------------
	// S1: cell differences, exact in W+1 bits
	// ------------------------------------------------------------------
	logic signed [W-1:0] wl_s1, wr_s1;
	logic signed [W:0]   d0_s1, d1_s1, d2_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			wl_s1 <= samples.near_left;
			wr_s1 <= samples.near_right;
			d0_s1 <= {samples.near_left[W-1], samples.near_left}
				- {samples.far_left[W-1], samples.far_left};
			d1_s1 <= {samples.near_right[W-1], samples.near_right}
				- {samples.near_left[W-1], samples.near_left};
			d2_s1 <= {samples.far_right[W-1], samples.far_right}
				- {samples.near_right[W-1], samples.near_right};
		end
	end

	// ------------------------------------------------------------------
	// S2: ratio setup. Lane 0 is the left face, lane 1 the right face.
	// |num|*S / |den|; the first compare of the long division doubles as
	// the saturation test (quotient >= 2^(W-1)).
	// ------------------------------------------------------------------
	logic [W:0]     r0_s2   [2];
	logic [W-2:0]   nlo_s2  [2];
	logic [W:0]     den_s2  [2];
	ratio_side_t    rside_s2 [2];

	always_ff @(posedge clk) begin
		logic signed [W:0] num, den;
		logic [W:0]        num_m, den_m, r0;
		logic [W+F:0]      nfull;
		logic              sat;
		if (ce) begin
			for (int l = 0; l < 2; l++) begin
				num   = (l == 0) ? d0_s1 : d1_s1;
				den   = (l == 0) ? d1_s1 : d2_s1;
				num_m = mag_f(num);
				den_m = (den == '0) ? (W + 1)'(1) : mag_f(den);
				nfull = {num_m, {F{1'b0}}};
				r0    = (W + 1)'(nfull >> (W - 1));
				sat   = r0 >= den_m;
				r0_s2[l]         <= sat ? '0 : r0;
				nlo_s2[l]        <= nfull[W-2:0];
				den_s2[l]        <= den_m;
				rside_s2[l].sat  <= sat;
				rside_s2[l].neg  <= num[W] ^ den[W];
				rside_s2[l].base <= (l == 0) ? wl_s1 : wr_s1;
				rside_s2[l].diff <= den;
			end
		end
	end

	// ------------------------------------------------------------------
	// Ratio dividers: W-1 stages
	// ------------------------------------------------------------------
	logic [RM-1:0] rq_da    [2];
	ratio_side_t   rside_da [2];

	mlfr_div_pipe #(
		.DW(W + 1), .QW(RM), .PW($bits(ratio_side_t))
	) u_ratio_div_l (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.in_valid(v_s2), .in_rem(r0_s2[0]), .in_num(nlo_s2[0]), .in_den(den_s2[0]),
		.in_side(rside_s2[0]),
		.out_valid(v_da), .out_quo(rq_da[0]), .out_side(rside_da[0])
	);

	mlfr_div_pipe #(
		.DW(W + 1), .QW(RM), .PW($bits(ratio_side_t))
	) u_ratio_div_r (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.in_valid(v_s2), .in_rem(r0_s2[1]), .in_num(nlo_s2[1]), .in_den(den_s2[1]),
		.in_side(rside_s2[1]),
		.out_valid(v_da_r), .out_quo(rq_da[1]), .out_side(rside_da[1])
	);

	// ------------------------------------------------------------------
	// S3: signed, saturated ratio
	// ------------------------------------------------------------------
	logic signed [W-1:0] r_s3    [2];
	logic signed [W-1:0] base_s3 [2];
	logic signed [W:0]   diff_s3 [2];

	always_ff @(posedge clk) begin
		logic [W-1:0] rm;
		if (ce) begin
			for (int l = 0; l < 2; l++) begin
				rm = rside_da[l].sat ? {1'b0, {RM{1'b1}}} : {1'b0, rq_da[l]};
				r_s3[l]    <= rside_da[l].neg ? -rm : rm;
				base_s3[l] <= rside_da[l].base;
				diff_s3[l] <= rside_da[l].diff;
			end
		end
	end

	// ------------------------------------------------------------------
	// S4: limiter products |r|*|r+S| and r^2
	// ------------------------------------------------------------------
	logic signed [W-1:0]  r_s4     [2];
	logic signed [W:0]    rps_s4   [2];
	logic                 vaneg_s4 [2];
	logic [RM+W-1:0]      pa_s4    [2];
	logic [2*RM-1:0]      pb_s4    [2];
	logic signed [W-1:0]  base_s4  [2];
	logic signed [W:0]    diff_s4  [2];

	always_ff @(posedge clk) begin
		logic signed [W:0] rps;
		logic [RM-1:0]     rmag;
		logic [W-1:0]      rpsmag;
		if (ce) begin
			for (int l = 0; l < 2; l++) begin
				rps    = {r_s3[l][W-1], r_s3[l]} + ONE_X;
				rmag   = r_s3[l][W-1] ? RM'(-r_s3[l]) : RM'(r_s3[l]);
				rpsmag = rps[W] ? W'(-rps) : W'(rps);
				r_s4[l]     <= r_s3[l];
				rps_s4[l]   <= rps;
				vaneg_s4[l] <= r_s3[l][W-1] && !rps[W] && (rps != '0);
				pa_s4[l]    <= rmag * rpsmag;
				pb_s4[l]    <= rmag * rmag;
				base_s4[l]  <= base_s3[l];
				diff_s4[l]  <= diff_s3[l];
			end
		end
	end

	// ------------------------------------------------------------------
	// S5: limiter quotient setup. van Albada |r||r+S|S / (r^2+S^2),
	// van Leer 2rS / (r+S); both below 2S, so F+1 quotient bits.
	// None and minmod need no divide and ride along as a bypass value.
	// ------------------------------------------------------------------
	logic [LDW-1:0] lr0_s5   [2];
	logic [F:0]     lnlo_s5  [2];
	logic [LDW-1:0] lden_s5  [2];
	lim_side_t      lside_s5 [2];

	always_ff @(posedge clk) begin
		logic [LNW-1:0]      n;
		logic [LDW-1:0]      d;
		logic                rpos, use_div, neg;
		logic signed [PHW-1:0] byp;
		if (ce) begin
			for (int l = 0; l < 2; l++) begin
				rpos    = !r_s4[l][W-1] && (r_s4[l] != '0);
				n       = '0;
				d       = LDW'(1);
				use_div = 1'b0;
				neg     = 1'b0;
				byp     = '0;
				case (kind_q)
					mlfr_pkg::LIM_VAN_ALBADA: begin
						n       = {pa_s4[l], {F{1'b0}}};
						d       = LDW'(pb_s4[l]) + ONE_SQ;
						use_div = 1'b1;
						neg     = vaneg_s4[l];
					end
					mlfr_pkg::LIM_VAN_LEER: begin
						n       = LNW'(r_s4[l][W-2:0]) << (F + 1);
						d       = LDW'(rps_s4[l][W-1:0]);
						use_div = rpos;
					end
					mlfr_pkg::LIM_MINMOD: begin
						if (r_s4[l][W-1]) byp = '0;
						else if (r_s4[l] > $signed(ONE_W)) byp = PHW'(ONE_W);
						else byp = PHW'(r_s4[l]);
					end
					default: byp = '0;
				endcase
				lr0_s5[l]           <= LDW'(n >> (F + 1));
				lnlo_s5[l]          <= n[F:0];
				lden_s5[l]          <= d;
				lside_s5[l].use_div <= use_div;
				lside_s5[l].neg     <= neg;
				lside_s5[l].byp     <= byp;
				lside_s5[l].base    <= base_s4[l];
				lside_s5[l].diff    <= diff_s4[l];
			end
		end
	end

	// ------------------------------------------------------------------
	// Limiter dividers: F+1 stages
	// ------------------------------------------------------------------
	logic [F:0]  lq_dc    [2];
	lim_side_t   lside_dc [2];

	mlfr_div_pipe #(
		.DW(LDW), .QW(F + 1), .PW($bits(lim_side_t))
	) u_lim_div_l (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.in_valid(v_s5), .in_rem(lr0_s5[0]), .in_num(lnlo_s5[0]), .in_den(lden_s5[0]),
		.in_side(lside_s5[0]),
		.out_valid(v_dc), .out_quo(lq_dc[0]), .out_side(lside_dc[0])
	);

	mlfr_div_pipe #(
		.DW(LDW), .QW(F + 1), .PW($bits(lim_side_t))
	) u_lim_div_r (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.in_valid(v_s5), .in_rem(lr0_s5[1]), .in_num(lnlo_s5[1]), .in_den(lden_s5[1]),
		.in_side(lside_s5[1]),
		.out_valid(v_dc_r), .out_quo(lq_dc[1]), .out_side(lside_dc[1])
	);

	// ------------------------------------------------------------------
	// S6: phi, then magnitudes for the correction multiply. The right face
	// subtracts, so its sign flips here.
	// ------------------------------------------------------------------
	logic [F:0]          phim_s6 [2];
	logic [W:0]          dm_s6   [2];
	logic                cneg_s6 [2];
	logic signed [W-1:0] base_s6 [2];

	always_ff @(posedge clk) begin
		logic signed [PHW-1:0] q, phi;
		if (ce) begin
			for (int l = 0; l < 2; l++) begin
				q   = PHW'(lq_dc[l]);
				phi = lside_dc[l].use_div ? (lside_dc[l].neg ? -q : q) : lside_dc[l].byp;
				phim_s6[l] <= phi[PHW-1] ? (F + 1)'(-phi) : (F + 1)'(phi);
				dm_s6[l]   <= mag_f(lside_dc[l].diff);
				cneg_s6[l] <= phi[PHW-1] ^ lside_dc[l].diff[W] ^ (l == 1);
				base_s6[l] <= lside_dc[l].base;
			end
		end
	end

	// ------------------------------------------------------------------
	// S7: |phi| * |diff|
	// ------------------------------------------------------------------
	logic [F+W+1:0]      prod_s7 [2];
	logic                cneg_s7 [2];
	logic signed [W-1:0] base_s7 [2];

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < 2; l++) begin
				prod_s7[l] <= phim_s6[l] * dm_s6[l];
				cneg_s7[l] <= cneg_s6[l];
				base_s7[l] <= base_s6[l];
			end
		end
	end

	// ------------------------------------------------------------------
	// S8: truncate by 2S, apply sign, add to the cell value, saturate.
	// This is also the output register.
	// ------------------------------------------------------------------
	logic signed [W-1:0] face_s8 [2];

	always_ff @(posedge clk) begin
		logic [W:0]          cmag;
		logic signed [W+1:0] corr, sum;
		if (ce) begin
			for (int l = 0; l < 2; l++) begin
				cmag = (W + 1)'(prod_s7[l] >> (F + 1));
				corr = cneg_s7[l] ? -{1'b0, cmag} : {1'b0, cmag};
				sum  = {{2{base_s7[l][W-1]}}, base_s7[l]} + corr;
				if (sum[W+1] && !(sum[W] && sum[W-1]))
					face_s8[l] <= {1'b1, {(W - 1){1'b0}}};
				else if (!sum[W+1] && (sum[W] || sum[W-1]))
					face_s8[l] <= {1'b0, {(W - 1){1'b1}}};
				else
					face_s8[l] <= sum[W-1:0];
			end
		end
	end

	assign faces.valid      = v_s8;
	assign faces.left_face  = face_s8[0];
	assign faces.right_face = face_s8[1];

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// input is refused only while stage 1 holds a beat
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> v_s1)
		else $error("input refused with empty first stage");

	// a stalled pipe keeps the beat sitting in stage 1
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && !faces.ready && v_s1) |=> v_s1)
		else $error("stage 1 beat lost during stall");

	// both lanes of each divider pair stay in lockstep
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(v_da == v_da_r) && (v_dc == v_dc_r))
		else $error("divider lanes out of step");

endmodule

>>> tb/tb_mlfr_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mlfr_if
// Testbench copy point for the block's channel interfaces; the RTL file
// declares them, so this file only holds shared testbench constants.
// ----------------------------------------------------------------------------
package tb_mlfr_pkg;

	localparam int WB = 32;
	localparam int FB = 16;
	localparam int PIPE_LAT = WB + FB + 7;

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams cell quadruples through the MUSCL face reconstruction block under
// each limiter setting and checks every face pair against an in-bench
// fixed-point predictor, with random idle on both channels and a long
// output hold-off to fill the pipe.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WB = tb_mlfr_pkg::WB;
	localparam int FB = tb_mlfr_pkg::FB;
	localparam int PIPE_LAT = tb_mlfr_pkg::PIPE_LAT;

	typedef struct {
		logic signed [WB-1:0] lf;
		logic signed [WB-1:0] rf;
	} face_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int unsigned cycle_cnt = 0;
	bit failed = 1'b0;

	// idle odds out of a hundred for sender and receiver
	int unsigned src_idle = 0;
	int unsigned snk_stall = 0;
	int unsigned hold_off = 0;

	mlfr_pkg::limiter_kind_t lim_sel = mlfr_pkg::LIM_NONE;
	face_pair_t face_q[$];

	mlfr_in_if #(.WORD_BITS(WB)) samples();
	mlfr_out_if #(.WORD_BITS(WB)) faces();
	mlfr_cfg_if cfg();

	muscl_limited_face_reconstruct #(.WORD_BITS(WB), .FRAC_BITS(FB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples.sink),
		.faces(faces.source),
		.cfg(cfg.sink)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		samples.valid = 1'b0;
		samples.far_left = '0;
		samples.near_left = '0;
		samples.near_right = '0;
		samples.far_right = '0;
		cfg.valid = 1'b0;
		cfg.data = mlfr_pkg::LIM_NONE;
		faces.ready = 1'b0;
	end

	// generous cap: ~2000 items, some under heavy input idle, plus latency and stalls
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 600000) begin
			$display("muscl_limited_face_reconstruct: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor. Widths chosen so nothing here can overflow: the ratio is
	// at most 31 bits, squares fit in 64, times S fits in 128.
	// ------------------------------------------------------------------
	localparam longint WMAX_V = (64'sd1 <<< (WB-1)) - 1;
	localparam longint WMIN_V = -(64'sd1 <<< (WB-1));
	localparam longint ONE_V = 64'sd1 <<< FB;

	function automatic longint smooth_ratio(longint num, longint den);
		logic [127:0] q;
		logic [127:0] nm;
		logic [127:0] dm;
		nm = (num < 0) ? -num : num;
		dm = (den == 0) ? 1 : ((den < 0) ? -den : den);
		q = (nm << FB) / dm;
		if (q > WMAX_V) q = WMAX_V;
		return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint phi_of(mlfr_pkg::limiter_kind_t k, longint r);
		logic [127:0] n;
		logic [127:0] d;
		logic [127:0] ra;
		logic [127:0] rb;
		ra = (r < 0) ? -r : r;
		rb = (r + ONE_V < 0) ? -(r + ONE_V) : (r + ONE_V);
		case (k)
			mlfr_pkg::LIM_VAN_ALBADA: begin
				n = ra * rb * ONE_V;
				d = ra * ra + ONE_V * ONE_V;
				return (r < 0 && r + ONE_V > 0) ? -longint'(n / d) : longint'(n / d);
			end
			mlfr_pkg::LIM_VAN_LEER: begin
				if (r <= 0) return 0;
				n = 128'(r) * 2 * ONE_V;
				d = 128'(r + ONE_V);
				return longint'(n / d);
			end
			mlfr_pkg::LIM_MINMOD: return (r < 0) ? 0 : ((r > ONE_V) ? ONE_V : r);
			default: return 0;
		endcase
	endfunction

	function automatic longint slope_term(longint phi, longint diff);
		logic [127:0] q;
		logic [127:0] pm;
		logic [127:0] dm;
		pm = (phi < 0) ? -phi : phi;
		dm = (diff < 0) ? -diff : diff;
		q = (pm * dm) / (2 * ONE_V);
		return ((phi < 0) != (diff < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clamp_word(longint v);
		return (v > WMAX_V) ? WMAX_V : ((v < WMIN_V) ? WMIN_V : v);
	endfunction

	function automatic face_pair_t predict_faces(mlfr_pkg::limiter_kind_t k,
			logic signed [WB-1:0] wll, logic signed [WB-1:0] wl,
			logic signed [WB-1:0] wr, logic signed [WB-1:0] wrr);
		face_pair_t fp;
		longint d0;
		longint d1;
		longint d2;
		longint pl;
		longint pr;
		d0 = longint'(wl) - longint'(wll);
		d1 = longint'(wr) - longint'(wl);
		d2 = longint'(wrr) - longint'(wr);
		pl = phi_of(k, smooth_ratio(d0, d1));
		pr = phi_of(k, smooth_ratio(d1, d2));
		fp.lf = WB'(clamp_word(longint'(wl) + slope_term(pl, d1)));
		fp.rf = WB'(clamp_word(longint'(wr) - slope_term(pr, d2)));
		return fp;
	endfunction

	// ------------------------------------------------------------------
	// Output side: random stall, long hold-off counted here, and checks
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		face_pair_t exp_fp;
		if (arst_n) begin
			if (faces.valid && faces.ready) begin
				if (face_q.size() == 0) begin
					$display("%0t: unexpected face beat lf=%h rf=%h", $time,
						faces.left_face, faces.right_face);
					failed = 1'b1;
				end else begin
					exp_fp = face_q.pop_front();
					if (faces.left_face !== exp_fp.lf) begin
						$display("%0t: left_face exp %h got %h", $time, exp_fp.lf,
							faces.left_face);
						failed = 1'b1;
					end
					if (faces.right_face !== exp_fp.rf) begin
						$display("%0t: right_face exp %h got %h", $time, exp_fp.rf,
							faces.right_face);
						failed = 1'b1;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				faces.ready <= 1'b0;
			end else begin
				faces.ready <= ($urandom_range(99) >= snk_stall);
			end
		end
	end

	// one input beat; expectation queued at acceptance. valid stays up after
	// the beat so the next call can follow back to back.
	task automatic send_cells(logic signed [WB-1:0] wll, logic signed [WB-1:0] wl,
			logic signed [WB-1:0] wr, logic signed [WB-1:0] wrr);
		while ($urandom_range(99) < src_idle) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.far_left <= wll;
		samples.near_left <= wl;
		samples.near_right <= wr;
		samples.far_right <= wrr;
		do @(posedge clk); while (!samples.ready);
		face_q.push_back(predict_faces(lim_sel, wll, wl, wr, wrr));
	endtask

	// drain, settle, then write the limiter select
	task automatic set_limiter(mlfr_pkg::limiter_kind_t k);
		samples.valid <= 1'b0;
		while (face_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= k;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		lim_sel = k;
	endtask

	function automatic logic [WB-1:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom;
			1: return WB'($signed($urandom_range(2000)) - 1000);
			2: return {1'b0, {(WB-1){1'b1}}} - $urandom_range(3);
			3: return {1'b1, {(WB-1){1'b0}}} + $urandom_range(3);
			default: return WB'($signed($urandom_range(32'h000fffff)) - 32'sh0007ffff);
		endcase
	endfunction

	// smooth ramp with random slope, noise, or a sharp step
	task automatic send_random(int n);
		logic signed [WB-1:0] base;
		logic signed [WB-1:0] step;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(2) == 0) begin
				send_cells(rand_word(), rand_word(), rand_word(), rand_word());
			end else begin
				base = rand_word();
				step = WB'($signed($urandom_range(32'h0003ffff)) - 32'sh0001ffff);
				send_cells(base, base + step + $signed($urandom_range(15)) - 7,
					base + 2 * step, base + 3 * step + $signed($urandom_range(255)) - 127);
			end
		end
	endtask

	task automatic test_directed();
		logic signed [WB-1:0] mx;
		logic signed [WB-1:0] mn;
		mx = {1'b0, {(WB-1){1'b1}}};
		mn = {1'b1, {(WB-1){1'b0}}};
		send_cells(0, 0, 0, 0);                 // both denominators zero
		send_cells(0, 32'h10000, 32'h10000, 32'h20000);
		send_cells(0, 32'h10000, 32'h20000, 32'h30000); // uniform ramp, r = 1
		send_cells(mn, mx, mn, mx);             // extreme diffs, sign flips
		send_cells(mx, mn, mx, mn);
		send_cells(mx, mx, mx, mx);
		send_cells(mn, mn, mn, mn);
		send_cells(mn, mx, mx, mn);             // ratio saturation
		send_cells(0, 32'h7fff0000, 32'h7fff0001, 32'h7fff0002);
		send_cells(32'h20000, 32'h10000, 32'h20000, 32'h10000); // r = -1
		send_cells(0, 32'h30000, 32'h40000, 32'h40001);
		send_cells(-1, 0, 1, 3);
		send_cells(32'hffffffff, 32'h55555555, 32'haaaaaaaa, 32'h0);
	endtask

	task automatic test_limiter(mlfr_pkg::limiter_kind_t k);
		set_limiter(k);
		test_directed();
		src_idle = 0;  snk_stall = 0;  send_random(120);
		src_idle = 87; snk_stall = 0;  send_random(60);
		src_idle = 0;  snk_stall = 87; send_random(60);
		src_idle = 20; snk_stall = 20; send_random(100);
		src_idle = 0;  snk_stall = 0;
	endtask

	// receiver held off long enough that the pipe fills and input stalls
	task automatic test_backpressure();
		hold_off = 300;
		send_random(150);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();        // reset setting: no limiter
		test_limiter(mlfr_pkg::LIM_VAN_ALBADA);
		test_limiter(mlfr_pkg::LIM_VAN_LEER);
		test_backpressure();
		test_limiter(mlfr_pkg::LIM_MINMOD);
		test_limiter(mlfr_pkg::LIM_NONE);
		test_limiter(mlfr_pkg::LIM_MINMOD);
		samples.valid <= 1'b0;
		while (face_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
		if (!failed)
			$display("muscl_limited_face_reconstruct: match");
		else
			$display("muscl_limited_face_reconstruct: mismatch");
		$finish;
	end
endmodule
